@@ hdl/bpc_pkg.sv @@
// Shared types, register codes and arithmetic helpers for the box-plane collision response block.
package bpc_pkg;

  localparam int IN_TDATA_W  = 336;
  localparam int OUT_TDATA_W = 200;
  localparam int BOX_W       = 331;
  localparam int RES_W       = 196;

  localparam logic [1:0] REG_PLANE_POS_X    = 2'd0;
  localparam logic [1:0] REG_PLANE_POS_Y    = 2'd1;
  localparam logic [1:0] REG_PLANE_NORMAL_X = 2'd2;
  localparam logic [1:0] REG_PLANE_NORMAL_Y = 2'd3;

  localparam logic signed [15:0] NORMAL_Y_RESET = 16'sd16384;
  localparam logic [16:0]        ONE_Q14        = 17'd16384;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } plane_t;

  typedef struct packed {
    logic        [14:0] bounciness;
    logic        [30:0] box_moment;
    logic        [30:0] box_mass;
    logic        [30:0] box_height;
    logic        [30:0] box_width;
    logic signed [15:0] axis_sin;
    logic signed [15:0] axis_cos;
    logic signed [31:0] spin_rate;
    logic signed [31:0] box_vel_y;
    logic signed [31:0] box_vel_x;
    logic signed [31:0] box_pos_y;
    logic signed [31:0] box_pos_x;
  } box_t;

  typedef struct packed {
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] lever_y;
    logic signed [31:0] lever_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_x;
    logic        [2:0]  contact_count;
    logic               hit;
  } result_t;

  typedef struct packed {
    logic        [2:0]  count;
    logic signed [50:0] sv;
    logic signed [33:0] sox;
    logic signed [33:0] soy;
    logic signed [50:0] pen;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic        [30:0] mass;
    logic        [30:0] moment;
    logic        [14:0] bounce;
  } contact_t;

  typedef struct packed {
    logic        [2:0]  count;
    logic signed [33:0] lx;
    logic signed [33:0] ly;
    logic signed [31:0] k;
    logic signed [36:0] pen16;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] rabs;
    logic [30:0] mass;
    logic [30:0] moment;
  } avg_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] meff;
  } emass_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // one radix-16 digit of a division by three: {quotient digit, remainder}
  function automatic logic [5:0] div3_nib(input logic [1:0] rem, input logic [3:0] nib);
    logic [2:0] r;
    logic [3:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int j = 3; j >= 0; j--) begin
      r = {r[1:0], nib[j]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
        q[j] = 1'b1;
      end
    end
    return {q, r[1:0]};
  endfunction

endpackage

@@ hdl/box_plane_collision_response_top.sv @@
// Top level: plane registers, stream unpacking and the four pipeline sections.
// Pipeline from an accepted input word to its output word: 6 geometry, 6 averaging,
// 35 effective-mass divider and 4 force stages. Throughput one word per cycle while
// m_axis_tready is high; the 32 divider stages each yield one quotient bit.
// Synchronous reset clears all valid bits and sets the plane to point (0, 0),
// normal (0, 1.0).
module box_plane_collision_response_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_addr,
  input  logic [31:0]                         cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // box_pos_x, box_pos_y, box_vel_x, box_vel_y, spin_rate, axis_cos, axis_sin,
  // box_width, box_height, box_mass, box_moment, bounciness, zero pad
  input  logic [bpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit, contact_count, force_x, force_y, lever_x, lever_y, new_pos_x,
  // new_pos_y, zero pad
  output logic [bpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import bpc_pkg::*;

  plane_t   plane;
  box_t     box;
  contact_t geo_c;
  avg_t     avg_a;
  emass_t   em_e;
  result_t  res;
  logic     geo_v, geo_r, avg_v, avg_r, em_v, em_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane.px <= '0;
      plane.py <= '0;
      plane.nx <= '0;
      plane.ny <= NORMAL_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PLANE_POS_X:    plane.px <= cfg_data;
        REG_PLANE_POS_Y:    plane.py <= cfg_data;
        REG_PLANE_NORMAL_X: plane.nx <= cfg_data[15:0];
        REG_PLANE_NORMAL_Y: plane.ny <= cfg_data[15:0];
      endcase
    end
  end

  assign box = box_t'(s_axis_tdata[BOX_W-1:0]);

  bpc_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_box    (box),
    .out_valid (geo_v),
    .out_ready (geo_r),
    .out_c     (geo_c)
  );

  bpc_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane),
    .in_valid  (geo_v),
    .in_ready  (geo_r),
    .in_c      (geo_c),
    .out_valid (avg_v),
    .out_ready (avg_r),
    .out_a     (avg_a)
  );

  bpc_emass u_emass (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (avg_v),
    .in_ready  (avg_r),
    .in_a      (avg_a),
    .out_valid (em_v),
    .out_ready (em_r),
    .out_e     (em_e)
  );

  bpc_force u_force (
    .clk       (clk),
    .rst       (rst),
    .plane     (plane),
    .in_valid  (em_v),
    .in_ready  (em_r),
    .in_e      (em_e),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_r     (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), res};

endmodule

@@ hdl/bpc_geom.sv @@
// Corner offsets, point velocities, contact test and contact sums.
module bpc_geom (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::plane_t   plane,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpc_pkg::box_t     in_box,
  output logic              out_valid,
  input  logic              out_ready,
  output bpc_pkg::contact_t out_c
);
  import bpc_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  logic [NST-1:0] vsrc;
  logic signed [15:0] nx, ny;

  assign nx = $signed(plane.nx);
  assign ny = $signed(plane.ny);
  assign vsrc = {vld[NST-2:0], in_valid};

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) if (rdy[i]) vld[i] <= vsrc[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  // stage 1
  logic signed [32:0] s1_dx, s1_dy;
  logic signed [47:0] s1_wc, s1_ws, s1_hc, s1_hs;
  box_t               s1_box;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dx  <= 33'($signed(in_box.box_pos_x)) - 33'($signed(plane.px));
      s1_dy  <= 33'($signed(in_box.box_pos_y)) - 33'($signed(plane.py));
      s1_wc  <= 48'($signed({1'b0, in_box.box_width})) * 48'($signed(in_box.axis_cos));
      s1_ws  <= 48'($signed({1'b0, in_box.box_width})) * 48'($signed(in_box.axis_sin));
      s1_hc  <= 48'($signed({1'b0, in_box.box_height})) * 48'($signed(in_box.axis_cos));
      s1_hs  <= 48'($signed({1'b0, in_box.box_height})) * 48'($signed(in_box.axis_sin));
      s1_box <= in_box;
    end
  end

  // stage 2
  logic signed [47:0] xw[4], xs[4], yw[4], yh[4];
  logic signed [48:0] tx[4], ty[4];
  logic signed [31:0] ox_c[4], oy_c[4];
  logic signed [49:0] come_c;

  always_comb begin
    come_c = 50'(s1_dx) * 50'(nx) + 50'(s1_dy) * 50'(ny);
    for (int i = 0; i < 4; i++) begin
      xw[i]   = ((i & 1) != 0) ? s1_wc : -s1_wc;
      xs[i]   = ((i & 2) != 0) ? s1_hs : -s1_hs;
      yw[i]   = ((i & 1) != 0) ? s1_ws : -s1_ws;
      yh[i]   = ((i & 2) != 0) ? s1_hc : -s1_hc;
      tx[i]   = 49'(xw[i]) - 49'(xs[i]) + 49'sd16384;
      ty[i]   = 49'(yw[i]) + 49'(yh[i]) + 49'sd16384;
      ox_c[i] = sat32(72'(tx[i] >>> 15));
      oy_c[i] = sat32(72'(ty[i] >>> 15));
    end
  end

  logic signed [49:0] s2_come;
  logic signed [31:0] s2_ox[4], s2_oy[4];
  box_t               s2_box;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_come <= come_c;
      s2_ox   <= ox_c;
      s2_oy   <= oy_c;
      s2_box  <= s1_box;
    end
  end

  // stage 3
  logic signed [49:0] s3_come;
  logic signed [50:0] s3_dist[4];
  logic signed [63:0] s3_sox[4], s3_soy[4];
  logic signed [31:0] s3_ox[4], s3_oy[4];
  box_t               s3_box;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 4; i++) begin
        s3_dist[i] <= 51'(s2_come) + 51'(s2_ox[i]) * 51'(nx) + 51'(s2_oy[i]) * 51'(ny);
        s3_sox[i]  <= 64'($signed(s2_box.spin_rate)) * 64'(s2_ox[i]);
        s3_soy[i]  <= 64'($signed(s2_box.spin_rate)) * 64'(s2_oy[i]);
      end
      s3_come <= s2_come;
      s3_ox   <= s2_ox;
      s3_oy   <= s2_oy;
      s3_box  <= s2_box;
    end
  end

  // stage 4
  logic signed [71:0] tvx[4], tvy[4];
  logic signed [31:0] pvx_c[4], pvy_c[4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tvx[i]   = 72'sd32768 - 72'(s3_soy[i]);
      tvy[i]   = 72'(s3_sox[i]) + 72'sd32768;
      pvx_c[i] = sat32(72'($signed(s3_box.box_vel_x)) + (tvx[i] >>> 16));
      pvy_c[i] = sat32(72'($signed(s3_box.box_vel_y)) + (tvy[i] >>> 16));
    end
  end

  logic signed [49:0] s4_come;
  logic signed [50:0] s4_dist[4];
  logic signed [31:0] s4_pvx[4], s4_pvy[4], s4_ox[4], s4_oy[4];
  box_t               s4_box;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_come <= s3_come;
      s4_dist <= s3_dist;
      s4_pvx  <= pvx_c;
      s4_pvy  <= pvy_c;
      s4_ox   <= s3_ox;
      s4_oy   <= s3_oy;
      s4_box  <= s3_box;
    end
  end

  // stage 5
  logic signed [49:0] s5_come;
  logic signed [50:0] s5_dist[4];
  logic signed [48:0] s5_vin[4];
  logic signed [31:0] s5_ox[4], s5_oy[4];
  box_t               s5_box;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 4; i++) begin
        s5_vin[i] <= 49'(s4_pvx[i]) * 49'(nx) + 49'(s4_pvy[i]) * 49'(ny);
      end
      s5_come <= s4_come;
      s5_dist <= s4_dist;
      s5_ox   <= s4_ox;
      s5_oy   <= s4_oy;
      s5_box  <= s4_box;
    end
  end

  // stage 6
  logic               hitc[4];
  logic [2:0]         cnt_c;
  logic signed [33:0] sox_c, soy_c;
  logic signed [50:0] sv_c, pen_c;

  always_comb begin
    cnt_c = '0;
    sox_c = '0;
    soy_c = '0;
    sv_c  = '0;
    pen_c = '0;
    for (int i = 0; i < 4; i++) begin
      hitc[i] = (s5_dist[i] > 0 && s5_come < 0 && s5_vin[i] > 0) ||
                (s5_dist[i] < 0 && s5_come > 0 && s5_vin[i] < 0);
      if (hitc[i]) begin
        cnt_c = cnt_c + 3'd1;
        sox_c = sox_c + 34'(s5_ox[i]);
        soy_c = soy_c + 34'(s5_oy[i]);
        sv_c  = sv_c + 51'(s5_vin[i]);
        if (s5_come >= 0) begin
          if (pen_c > s5_dist[i]) pen_c = s5_dist[i];
        end else begin
          if (pen_c < s5_dist[i]) pen_c = s5_dist[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_c.count  <= cnt_c;
      out_c.sv     <= sv_c;
      out_c.sox    <= sox_c;
      out_c.soy    <= soy_c;
      out_c.pen    <= pen_c;
      out_c.bx     <= s5_box.box_pos_x;
      out_c.by     <= s5_box.box_pos_y;
      out_c.mass   <= s5_box.box_mass;
      out_c.moment <= s5_box.box_moment;
      out_c.bounce <= s5_box.bounciness;
    end
  end

endmodule

@@ hdl/bpc_avg.sv @@
// Contact averages by count, restitution term and lever arm about the normal.
module bpc_avg (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::plane_t   plane,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpc_pkg::contact_t in_c,
  output logic              out_valid,
  input  logic              out_ready,
  output bpc_pkg::avg_t     out_a
);
  import bpc_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  logic [NST-1:0] vsrc;
  logic signed [15:0] nx, ny;

  assign nx = $signed(plane.nx);
  assign ny = $signed(plane.ny);
  assign vsrc = {vld[NST-2:0], in_valid};

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) if (rdy[i]) vld[i] <= vsrc[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  // stage 1: sign and magnitude
  logic               a1_vn, a1_xn, a1_yn;
  logic [51:0]        a1_vm;
  logic [35:0]        a1_xm, a1_ym;
  logic signed [51:0] sv_w;
  logic signed [35:0] sx_w, sy_w;
  logic signed [51:0] pen_w;
  contact_t           a1_c;
  logic signed [36:0] a1_pen16;

  always_comb begin
    sv_w  = 52'($signed(in_c.sv));
    sx_w  = 36'($signed(in_c.sox));
    sy_w  = 36'($signed(in_c.soy));
    pen_w = 52'($signed(in_c.pen)) + 52'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a1_vn    <= sv_w < 0;
      a1_xn    <= sx_w < 0;
      a1_yn    <= sy_w < 0;
      a1_vm    <= (sv_w < 0) ? 52'(-sv_w) : 52'(sv_w);
      a1_xm    <= (sx_w < 0) ? 36'(-sx_w) : 36'(sx_w);
      a1_ym    <= (sy_w < 0) ? 36'(-sy_w) : 36'(sy_w);
      a1_pen16 <= 37'(pen_w >>> 14);
      a1_c     <= in_c;
    end
  end

  // stage 2: upper digits of the division by three
  logic [51:0] vq2;
  logic [35:0] xq2, yq2;
  logic [1:0]  vr2, xr2, yr2;
  logic [5:0]  dv2[7], dx2[5], dy2[5];

  always_comb begin
    vq2 = '0;
    xq2 = '0;
    yq2 = '0;
    vr2 = '0;
    xr2 = '0;
    yr2 = '0;
    for (int j = 0; j < 7; j++) begin
      dv2[j] = div3_nib(vr2, a1_vm[4*(12-j) +: 4]);
      vq2[4*(12-j) +: 4] = dv2[j][5:2];
      vr2 = dv2[j][1:0];
    end
    for (int j = 0; j < 5; j++) begin
      dx2[j] = div3_nib(xr2, a1_xm[4*(8-j) +: 4]);
      dy2[j] = div3_nib(yr2, a1_ym[4*(8-j) +: 4]);
      xq2[4*(8-j) +: 4] = dx2[j][5:2];
      yq2[4*(8-j) +: 4] = dy2[j][5:2];
      xr2 = dx2[j][1:0];
      yr2 = dy2[j][1:0];
    end
  end

  logic              a2_vn, a2_xn, a2_yn;
  logic [51:0]       a2_vm, a2_vq;
  logic [35:0]       a2_xm, a2_ym, a2_xq, a2_yq;
  logic [1:0]        a2_vr, a2_xr, a2_yr;
  contact_t          a2_c;
  logic signed [36:0] a2_pen16;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      a2_vn    <= a1_vn;
      a2_xn    <= a1_xn;
      a2_yn    <= a1_yn;
      a2_vm    <= a1_vm;
      a2_xm    <= a1_xm;
      a2_ym    <= a1_ym;
      a2_vq    <= vq2;
      a2_xq    <= xq2;
      a2_yq    <= yq2;
      a2_vr    <= vr2;
      a2_xr    <= xr2;
      a2_yr    <= yr2;
      a2_c     <= a1_c;
      a2_pen16 <= a1_pen16;
    end
  end

  // stage 3: lower digits, then pick the quotient for the count
  logic [51:0] vq3, vsel;
  logic [35:0] xq3, yq3, xsel, ysel;
  logic [1:0]  vr3, xr3, yr3;
  logic [5:0]  dv3[6], dx3[4], dy3[4];

  always_comb begin
    vq3 = a2_vq;
    xq3 = a2_xq;
    yq3 = a2_yq;
    vr3 = a2_vr;
    xr3 = a2_xr;
    yr3 = a2_yr;
    for (int j = 0; j < 6; j++) begin
      dv3[j] = div3_nib(vr3, a2_vm[4*(5-j) +: 4]);
      vq3[4*(5-j) +: 4] = dv3[j][5:2];
      vr3 = dv3[j][1:0];
    end
    for (int j = 0; j < 4; j++) begin
      dx3[j] = div3_nib(xr3, a2_xm[4*(3-j) +: 4]);
      dy3[j] = div3_nib(yr3, a2_ym[4*(3-j) +: 4]);
      xq3[4*(3-j) +: 4] = dx3[j][5:2];
      yq3[4*(3-j) +: 4] = dy3[j][5:2];
      xr3 = dx3[j][1:0];
      yr3 = dy3[j][1:0];
    end
    unique case (a2_c.count)
      3'd1: begin
        vsel = a2_vm;
        xsel = a2_xm;
        ysel = a2_ym;
      end
      3'd2: begin
        vsel = a2_vm >> 1;
        xsel = a2_xm >> 1;
        ysel = a2_ym >> 1;
      end
      3'd3: begin
        vsel = vq3;
        xsel = xq3;
        ysel = yq3;
      end
      3'd4: begin
        vsel = a2_vm >> 2;
        xsel = a2_xm >> 2;
        ysel = a2_ym >> 2;
      end
      default: begin
        vsel = '0;
        xsel = '0;
        ysel = '0;
      end
    endcase
  end

  logic              a3_vn, a3_xn, a3_yn;
  logic [51:0]       a3_vm;
  logic [35:0]       a3_xm, a3_ym;
  contact_t          a3_c;
  logic signed [36:0] a3_pen16;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      a3_vn    <= a2_vn;
      a3_xn    <= a2_xn;
      a3_yn    <= a2_yn;
      a3_vm    <= vsel;
      a3_xm    <= xsel;
      a3_ym    <= ysel;
      a3_c     <= a2_c;
      a3_pen16 <= a2_pen16;
    end
  end

  // stage 4: restore signs, round the mean velocity
  logic signed [52:0] svq_w;
  logic signed [35:0] lx_w, ly_w;

  always_comb begin
    svq_w = a3_vn ? -$signed({1'b0, a3_vm}) : $signed({1'b0, a3_vm});
    lx_w  = a3_xn ? -$signed(a3_xm) : $signed(a3_xm);
    ly_w  = a3_yn ? -$signed(a3_ym) : $signed(a3_ym);
  end

  logic signed [37:0] a4_cv16;
  logic signed [33:0] a4_lx, a4_ly;
  contact_t           a4_c;
  logic signed [36:0] a4_pen16;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      a4_cv16  <= 38'((svq_w + 53'sd8192) >>> 14);
      a4_lx    <= lx_w[33:0];
      a4_ly    <= ly_w[33:0];
      a4_c     <= a3_c;
      a4_pen16 <= a3_pen16;
    end
  end

  // stage 5: products
  logic signed [55:0] a5_kp;
  logic signed [50:0] a5_rp;
  logic signed [33:0] a5_lx, a5_ly;
  contact_t           a5_c;
  logic signed [36:0] a5_pen16;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      a5_kp    <= 56'($signed({1'b0, ONE_Q14 + 17'(a4_c.bounce)})) * 56'(a4_cv16);
      a5_rp    <= 51'(a4_lx) * 51'(ny) - 51'(a4_ly) * 51'(nx);
      a5_lx    <= a4_lx;
      a5_ly    <= a4_ly;
      a5_c     <= a4_c;
      a5_pen16 <= a4_pen16;
    end
  end

  // stage 6: round, saturate, lever magnitude
  logic signed [56:0] kr_w;
  logic signed [51:0] rr_w;
  logic signed [37:0] r_w;
  logic [37:0]        ra_w;

  always_comb begin
    kr_w = 57'(a5_kp) + 57'sd8192;
    rr_w = 52'(a5_rp) + 52'sd8192;
    r_w  = 38'(rr_w >>> 14);
    ra_w = (r_w < 0) ? 38'(-r_w) : 38'(r_w);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      out_a.side.count <= a5_c.count;
      out_a.side.lx    <= a5_lx;
      out_a.side.ly    <= a5_ly;
      out_a.side.k     <= sat32(72'(kr_w >>> 14));
      out_a.side.pen16 <= a5_pen16;
      out_a.side.bx    <= a5_c.bx;
      out_a.side.by    <= a5_c.by;
      out_a.rabs       <= (ra_w > 38'h0FFFFFFFF) ? 32'hFFFFFFFF : ra_w[31:0];
      out_a.mass       <= (a5_c.mass == '0) ? 31'd1 : a5_c.mass;
      out_a.moment     <= (a5_c.moment == '0) ? 31'd1 : a5_c.moment;
    end
  end

endmodule

@@ hdl/bpc_emass.sv @@
// Effective mass m*I/(I + m*r*r) through a restoring divider, one quotient bit per stage.
module bpc_emass (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpc_pkg::avg_t   in_a,
  output logic            out_valid,
  input  logic            out_ready,
  output bpc_pkg::emass_t out_e
);
  import bpc_pkg::*;

  localparam int QB  = 32;
  localparam int NST = 3 + QB;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  logic [NST-1:0] vsrc;

  assign vsrc = {vld[NST-2:0], in_valid};

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) if (rdy[i]) vld[i] <= vsrc[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  // stage 1: r squared, m times I
  logic [63:0] e1_sq;
  logic [61:0] e1_mi;
  logic [30:0] e1_m, e1_i;
  side_t       e1_s;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      e1_sq <= 64'(in_a.rabs) * 64'(in_a.rabs);
      e1_mi <= 62'(in_a.mass) * 62'(in_a.moment);
      e1_m  <= in_a.mass;
      e1_i  <= in_a.moment;
      e1_s  <= in_a.side;
    end
  end

  // stage 2: m times r squared in two halves
  logic [62:0] e2_pl, e2_ph;
  logic [61:0] e2_mi;
  logic [30:0] e2_i;
  side_t       e2_s;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      e2_pl <= 63'(e1_m) * 63'(e1_sq[31:0]);
      e2_ph <= 63'(e1_m) * 63'(e1_sq[63:32]);
      e2_mi <= e1_mi;
      e2_i  <= e1_i;
      e2_s  <= e1_s;
    end
  end

  // stage 3: numerator and denominator
  logic [95:0] e3_num, e3_den;
  side_t       e3_s;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      e3_den <= (96'(e2_ph) << 32) + 96'(e2_pl) + (96'(e2_i) << 32);
      e3_num <= 96'(e2_mi) << 32;
      e3_s   <= e2_s;
    end
  end

  // quotient bits, most significant first
  logic [95:0] dnum[QB];
  logic [95:0] dden[QB];
  logic [31:0] dq[QB];
  side_t       dside[QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [95:0]  pnum, pden;
    logic [31:0]  pq;
    side_t        ps;
    logic [127:0] t;
    logic         take;

    if (j == 0) begin : g_first
      assign pnum = e3_num;
      assign pden = e3_den;
      assign pq   = '0;
      assign ps   = e3_s;
    end else begin : g_next
      assign pnum = dnum[j-1];
      assign pden = dden[j-1];
      assign pq   = dq[j-1];
      assign ps   = dside[j-1];
    end

    assign t    = 128'(pden) << (QB - 1 - j);
    assign take = t <= 128'(pnum);

    always_ff @(posedge clk) begin
      if (rdy[3+j]) begin
        dnum[j]  <= take ? 96'(128'(pnum) - t) : pnum;
        dden[j]  <= pden;
        dq[j]    <= pq | (take ? (32'd1 << (QB - 1 - j)) : 32'd0);
        dside[j] <= ps;
      end
    end
  end

  assign out_e.side = dside[QB-1];
  assign out_e.meff = dq[QB-1];

endmodule

@@ hdl/bpc_force.sv @@
// Force along the normal and depenetrated centre; holds the output word.
module bpc_force (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::plane_t  plane,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpc_pkg::emass_t  in_e,
  output logic             out_valid,
  input  logic             out_ready,
  output bpc_pkg::result_t out_r
);
  import bpc_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;
  logic [NST-1:0] vsrc;
  logic signed [15:0] nx, ny;

  assign nx = $signed(plane.nx);
  assign ny = $signed(plane.ny);
  assign vsrc = {vld[NST-2:0], in_valid};

  always_comb begin
    rdy[NST] = out_ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !vld[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) if (rdy[i]) vld[i] <= vsrc[i];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];

  // stage 1
  logic signed [63:0] f1_kmp;
  logic signed [53:0] f1_px, f1_py;
  side_t              f1_s;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      f1_kmp <= 64'($signed(in_e.side.k)) * 64'($signed({1'b0, in_e.meff}));
      f1_px  <= 54'(nx) * 54'($signed(in_e.side.pen16));
      f1_py  <= 54'(ny) * 54'($signed(in_e.side.pen16));
      f1_s   <= in_e.side;
    end
  end

  // stage 2
  logic signed [64:0] kmr_w;
  logic signed [71:0] pxr_w, pyr_w;
  logic signed [47:0] f2_km;
  logic signed [31:0] f2_npx, f2_npy;
  side_t              f2_s;

  always_comb begin
    kmr_w = 65'(f1_kmp) + 65'sd32768;
    pxr_w = (72'(f1_px) + 72'sd8192) >>> 14;
    pyr_w = (72'(f1_py) + 72'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      f2_km  <= 48'(kmr_w >>> 16);
      f2_npx <= sat32(72'($signed(f1_s.bx)) - pxr_w);
      f2_npy <= sat32(72'($signed(f1_s.by)) - pyr_w);
      f2_s   <= f1_s;
    end
  end

  // stage 3
  logic signed [63:0] f3_fxp, f3_fyp;
  logic signed [31:0] f3_npx, f3_npy;
  side_t              f3_s;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      f3_fxp <= 64'(nx) * 64'(f2_km);
      f3_fyp <= 64'(ny) * 64'(f2_km);
      f3_npx <= f2_npx;
      f3_npy <= f2_npy;
      f3_s   <= f2_s;
    end
  end

  // stage 4: output word
  logic signed [71:0] fxr_w, fyr_w;
  logic               any_c;

  always_comb begin
    fxr_w = (72'sd8192 - 72'(f3_fxp)) >>> 14;
    fyr_w = (72'sd8192 - 72'(f3_fyp)) >>> 14;
    any_c = f3_s.count != 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_r.hit           <= any_c;
      out_r.contact_count <= f3_s.count;
      out_r.force_x       <= any_c ? sat32(fxr_w) : 32'sd0;
      out_r.force_y       <= any_c ? sat32(fyr_w) : 32'sd0;
      out_r.lever_x       <= any_c ? f3_s.lx[31:0] : 32'sd0;
      out_r.lever_y       <= any_c ? f3_s.ly[31:0] : 32'sd0;
      out_r.new_pos_x     <= any_c ? f3_npx : f3_s.bx;
      out_r.new_pos_y     <= any_c ? f3_npy : f3_s.by;
    end
  end

endmodule
